// ===== rtl/tmtw_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer package
// Shared command and response types and character constants.
// -----------------------------------------------------------------------------
package tmtw_pkg;

   typedef enum logic [2:0] {
      OP_NOP     = 3'd0,
      OP_PRINT   = 3'd1,
      OP_NEWLINE = 3'd2,
      OP_TAB     = 3'd3,
      OP_BS      = 3'd4,
      OP_READ    = 3'd5,
      OP_SETCUR  = 3'd6
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  ch;
      logic [7:0]  color;
      logic [10:0] cell_idx;
      logic [6:0]  scol;
      logic [4:0]  srow;
   } cmd_type;

   typedef struct packed {
      logic [15:0] entry;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [7:0]  color;
   } rsp_type;

   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_SETCUR = 2'd2;

   localparam logic CSR_REVERSE_ROWS = 1'b0;
   localparam logic CSR_WRITE_COLOR  = 1'b1;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0]  COLOR_BRIGHT = 8'h0F;
   localparam logic [7:0]  COLOR_RESET  = 8'h07;
   localparam logic [15:0] CELL_BLANK   = 16'h0720;
   localparam logic [15:0] ATTR_MASK    = 16'hFF00;

endpackage

// ===== rtl/tmtw_front.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer front end
// Accepts beats, runs the escape decoder and the colour, and issues commands.
// -----------------------------------------------------------------------------
module tmtw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              hold,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        mode,
   input  logic [7:0]        ch,
   input  logic              eow,
   input  logic [10:0]       cell_idx,
   input  logic [6:0]        scol,
   input  logic [4:0]        srow,
   output logic              cmd_valid,
   output tmtw_pkg::cmd_type cmd,
   input  logic              cmd_full
);

   typedef enum logic [3:0] {
      ESC_IDLE  = 4'b0001,
      ESC_START = 4'b0010,
      ESC_FG    = 4'b0100,
      ESC_BG    = 4'b1000
   } esc_type;

   esc_type         esc_ff, esc_in;
   logic [3:0]      nib_ff, nib_in;
   logic [7:0]      color_ff, color_in;
   tmtw_pkg::op_type op;
   logic            accept;

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b <= 8'h39)      v = b - 8'h30;
      else if (b <= 8'h46) v = b - 8'h37;
      else                 v = b - 8'h57;
      return v[3:0];
   endfunction

   assign in_ready = !cmd_full && !hold;
   assign accept   = in_valid && in_ready;

   always_comb begin
      esc_in   = esc_ff;
      nib_in   = nib_ff;
      color_in = color_ff;
      op       = tmtw_pkg::OP_NOP;
      if (accept) begin
         case (mode)
            tmtw_pkg::MODE_WRITE: begin
               case (esc_ff)
                  ESC_START: begin
                     if (ch == tmtw_pkg::CH_R) begin
                        color_in = tmtw_pkg::COLOR_BRIGHT;
                        esc_in   = ESC_IDLE;
                     end else if (ch == tmtw_pkg::CH_C) begin
                        esc_in = ESC_FG;
                     end else begin
                        esc_in = ESC_IDLE;
                     end
                  end
                  ESC_FG: begin
                     nib_in = hex_value(ch);
                     esc_in = ESC_BG;
                  end
                  ESC_BG: begin
                     color_in = {hex_value(ch), nib_ff};
                     esc_in   = ESC_IDLE;
                  end
                  default: begin
                     if (ch == tmtw_pkg::CH_ESC) esc_in = ESC_START;
                     else if (ch == tmtw_pkg::CH_LF || ch == tmtw_pkg::CH_CR)
                        op = tmtw_pkg::OP_NEWLINE;
                     else if (ch == tmtw_pkg::CH_TAB) op = tmtw_pkg::OP_TAB;
                     else if (ch == tmtw_pkg::CH_BS)  op = tmtw_pkg::OP_BS;
                     else                              op = tmtw_pkg::OP_PRINT;
                  end
               endcase
               if (eow) esc_in = ESC_IDLE;
            end
            tmtw_pkg::MODE_READ:   op = tmtw_pkg::OP_READ;
            tmtw_pkg::MODE_SETCUR: op = tmtw_pkg::OP_SETCUR;
            default:               op = tmtw_pkg::OP_NOP;
         endcase
      end
   end

   assign cmd_valid    = accept;
   assign cmd.op       = op;
   assign cmd.ch       = ch;
   assign cmd.color    = color_in;
   assign cmd.cell_idx = cell_idx;
   assign cmd.scol     = scol;
   assign cmd.srow     = srow;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= ESC_IDLE;
         nib_ff   <= 4'd0;
         color_ff <= tmtw_pkg::COLOR_RESET;
      end else begin
         esc_ff   <= esc_in;
         nib_ff   <= nib_in;
         color_ff <= color_in;
      end
   end

endmodule

// ===== rtl/tmtw_queue.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer command queue
// Two-entry FIFO between front end and back end.
// -----------------------------------------------------------------------------
module tmtw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tmtw_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tmtw_pkg::cmd_type head
);

   tmtw_pkg::cmd_type data_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign head    = data_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tmtw_back.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer back end
// Owns the cell store and cursor; runs writes, reads, scrolls and the clear.
// -----------------------------------------------------------------------------
module tmtw_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              reverse_rows,
   input  logic              write_color,
   output logic              clearing,
   input  logic              cmd_valid,
   input  tmtw_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tmtw_pkg::rsp_type rsp
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_PUT_RD  = 9'b000000100,
      ST_PUT_WR  = 9'b000001000,
      ST_RD_WAIT = 9'b000010000,
      ST_SC_RD   = 9'b000100000,
      ST_SC_WR   = 9'b001000000,
      ST_SC_ZERO = 9'b010000000,
      ST_RESP    = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   tmtw_pkg::cmd_type cmd_ff, cmd_in;
   logic [CW-1:0]     col_ff, col_in, col_next;
   logic [RW-1:0]     row_ff, row_in;
   logic [RW-1:0]     sr_ff, sr_in;
   logic [CW-1:0]     sc_ff, sc_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [15:0]       entry_ff, entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tmtw_pkg::rsp_type rsp_ff, rsp_in;

   logic [15:0]       mem_ff [CELL_COUNT];
   logic [15:0]       rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [15:0]       mem_wdata;
   logic [7:0]        put_ch, put_color;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic rev);
      logic [RW-1:0] p;
      p = rev ? RW'(ROWS - 1) - row : row;
      return AW'(p * COLUMNS) + AW'(col);
   endfunction

   assign clearing  = state_ff == ST_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign col_next  = col_ff + 1'b1;

   always_comb begin
      put_ch    = (cmd_ff.op == tmtw_pkg::OP_TAB) ? tmtw_pkg::CH_SPACE : cmd_ff.ch;
      put_color = cmd_ff.color;
      if (cmd_ff.op == tmtw_pkg::OP_BS) begin
         put_ch    = 8'd0;
         put_color = 8'd0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      clr_in       = clr_ff;
      entry_in     = entry_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = 16'd0;
      mem_raddr    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = tmtw_pkg::CELL_BLANK;
            if (clr_ff == AW'(CELL_COUNT - 1)) state_in = ST_IDLE;
            else clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               entry_in = 16'd0;
               state_in = ST_RESP;
               case (cmd.op)
                  tmtw_pkg::OP_PRINT, tmtw_pkg::OP_TAB: state_in = ST_PUT_RD;
                  tmtw_pkg::OP_BS: begin
                     if (col_ff != '0) begin
                        col_in   = col_ff - 1'b1;
                        state_in = ST_PUT_RD;
                     end
                  end
                  tmtw_pkg::OP_NEWLINE: begin
                     col_in = '0;
                     if (row_ff == RW'(ROWS - 1)) begin
                        sr_in    = '0;
                        sc_in    = '0;
                        state_in = ST_SC_RD;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  tmtw_pkg::OP_READ: begin
                     mem_raddr = AW'(cmd.cell_idx);
                     if (32'(cmd.cell_idx) < 32'(CELL_COUNT)) state_in = ST_RD_WAIT;
                  end
                  tmtw_pkg::OP_SETCUR: begin
                     col_in = (32'(cmd.scol) < 32'(COLUMNS)) ? CW'(cmd.scol)
                                                              : CW'(COLUMNS - 1);
                     row_in = (32'(cmd.srow) < 32'(ROWS)) ? RW'(cmd.srow)
                                                           : RW'(ROWS - 1);
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_PUT_RD: begin
            mem_raddr = cell_addr(row_ff, col_ff, reverse_rows);
            state_in  = ST_PUT_WR;
         end
         ST_PUT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(row_ff, col_ff, reverse_rows);
            mem_wdata = write_color ? {put_color, put_ch}
                                    : ((rd_data_ff & tmtw_pkg::ATTR_MASK) | {8'd0, put_ch});
            state_in  = ST_RESP;
            if (cmd_ff.op != tmtw_pkg::OP_BS) begin
               if (col_ff == CW'(COLUMNS - 1)) begin
                  col_in = '0;
                  if (row_ff == RW'(ROWS - 1)) begin
                     sr_in    = '0;
                     sc_in    = '0;
                     state_in = ST_SC_RD;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_next;
                  if (cmd_ff.op == tmtw_pkg::OP_TAB && col_next[2:0] != 3'd0)
                     state_in = ST_PUT_RD;
               end
            end
         end
         ST_RD_WAIT: begin
            entry_in = rd_data_ff;
            state_in = ST_RESP;
         end
         ST_SC_RD: begin
            mem_raddr = cell_addr(sr_ff + 1'b1, sc_ff, reverse_rows);
            state_in  = ST_SC_WR;
         end
         ST_SC_WR: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(sr_ff, sc_ff, reverse_rows);
            mem_wdata = rd_data_ff;
            state_in  = ST_SC_RD;
            if (sc_ff == CW'(COLUMNS - 1)) begin
               sc_in = '0;
               if (sr_ff == RW'(ROWS - 2)) state_in = ST_SC_ZERO;
               else sr_in = sr_ff + 1'b1;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         ST_SC_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(RW'(ROWS - 1), sc_ff, reverse_rows);
            mem_wdata = 16'd0;
            if (sc_ff == CW'(COLUMNS - 1)) begin
               row_in   = RW'(ROWS - 1);
               state_in = ST_RESP;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.entry = entry_ff;
               rsp_in.col   = 7'(col_ff);
               rsp_in.row   = 5'(row_ff);
               rsp_in.color = cmd_ff.color;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      sr_ff    <= sr_in;
      sc_ff    <= sc_in;
      entry_ff <= entry_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/text_mode_terminal_writer_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text-mode terminal writer
// Character terminal over a COLUMNS x ROWS store of 16-bit cells.
// -----------------------------------------------------------------------------
// Steps: a printable byte goes through dispatch, cell read, cell write and
//   result; an in-range read through dispatch, cell read and result; cursor
//   set, escape byte and newline without scroll through dispatch and result;
//   a tab makes up to 8 cell writes. A scroll copies rows up, a read and a
//   write per cell, and zeroes the last row. Back end: one item at a time.
// Reset: synchronous, active high. Afterwards a clearing pass writes the blank
//   cell into all COLUMNS*ROWS entries with req_tready held low.
// -----------------------------------------------------------------------------
module text_mode_terminal_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] char_byte, [18:8] cell_index, [25:19] set_column, [30:26] set_row
   input  logic [31:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]  req_tuser,
   // end_of_write
   input  logic        req_tlast,
   // response beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] read_entry, [22:16] cursor_column, [27:23] cursor_row,
   // [35:28] text_color
   output logic [39:0] rsp_tdata,
   // register writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic        csr_wdata
);

   logic              reverse_ff, reverse_in;
   logic              wcolor_ff, wcolor_in;
   logic              clearing;
   logic              cmd_valid, q_full, q_empty, q_pop;
   tmtw_pkg::cmd_type cmd, q_head;
   tmtw_pkg::rsp_type rsp;

   // Register file: the user must write it only while the terminal is quiet; the block does not enforce this.
   always_comb begin
      reverse_in = reverse_ff;
      wcolor_in  = wcolor_ff;
      if (csr_we) begin
         case (csr_addr)
            tmtw_pkg::CSR_REVERSE_ROWS: reverse_in = csr_wdata;
            tmtw_pkg::CSR_WRITE_COLOR:  wcolor_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
         wcolor_ff  <= 1'b1;
      end else begin
         reverse_ff <= reverse_in;
         wcolor_ff  <= wcolor_in;
      end
   end

   // Front end: escape decoding and colour, one beat per cycle while the queue has room and no clearing pass runs.
   tmtw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .mode      (req_tuser),
      .ch        (req_tdata[7:0]),
      .eow       (req_tlast),
      .cell_idx  (req_tdata[18:8]),
      .scol      (req_tdata[25:19]),
      .srow      (req_tdata[30:26]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_full  (q_full)
   );

   // Decouples the decoder from long scroll and tab runs.
   tmtw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // Back end: cursor, cell store and response register.
   tmtw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .reverse_rows (reverse_ff),
      .write_color  (wcolor_ff),
      .clearing     (clearing),
      .cmd_valid    (!q_empty),
      .cmd          (q_head),
      .cmd_pop      (q_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.color, rsp.row, rsp.col, rsp.entry};

endmodule

// ===== rtl/tmtw_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer checker
// Port-level checks on response beats and reset.
// -----------------------------------------------------------------------------
module tmtw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("beat pending or ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[22:16]) < 32'(COLUMNS))
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[27:23]) < 32'(ROWS))
      else $error("cursor row out of range");

endmodule

bind text_mode_terminal_writer_unit tmtw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tmtw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_text_mode_terminal_writer_unit.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Text terminal writer testbench
// Drives mode/byte/cursor beats into the terminal writer and keeps a local
// model of the screen cells, cursor, colour and escape state. Every response
// beat is checked field by field against the oldest predicted response.
// Covers directed corner cases, register settings, random traffic with idle
// bursts on both sides, a long response stall and a full drain pause.
// -----------------------------------------------------------------------------
module tb_text_mode_terminal_writer_unit;

   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int CELLS      = COLS * ROWS;
   localparam int WDOG_LIMIT = 20000;   // longest scroll, clearing pass and stalls
   localparam int HOLD_LEN   = 500;     // long response hold-off, in cycles
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_OPEN  = 2'd1,   // ESC seen
      ESC_FG    = 2'd2,   // ESC c seen, waiting for first digit
      ESC_BG    = 2'd3    // first digit held, waiting for second
   } esc_phase_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_we;
   logic        csr_addr;
   logic        csr_wdata;

   text_mode_terminal_writer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Screen model
   // ---------------------------------------------------------------------------
   logic [15:0]   screen [CELLS];
   logic [6:0]    cur_col;
   logic [4:0]    cur_row;
   logic [7:0]    colour;
   esc_phase_type esc;
   logic [3:0]    fg_nib;
   logic          rev_rows;
   logic          keep_attr_off;   // write_color register

   tmtw_pkg::rsp_type expected_rsp [$];
   int          fails;
   bit          idling;          // random idle bursts enabled
   bit          hold_req;        // ask the receiver for one long hold-off
   int          quiet_cycles;

   function automatic int phys_row(int r);
      return rev_rows ? (ROWS - 1 - r) : r;
   endfunction

   task automatic put_cell(logic [7:0] ch, logic [7:0] attr, int col, int row);
      int idx;
      idx = phys_row(row) * COLS + col;
      if (keep_attr_off) screen[idx] = {attr, ch};
      else screen[idx] = {screen[idx][15:8], ch};
   endtask

   task automatic scroll_screen();
      for (int r = 0; r + 1 < ROWS; r++)
         for (int c = 0; c < COLS; c++)
            screen[phys_row(r) * COLS + c] = screen[phys_row(r + 1) * COLS + c];
      for (int c = 0; c < COLS; c++)
         screen[phys_row(ROWS - 1) * COLS + c] = 16'h0000;
      cur_row = ROWS - 1;
   endtask

   task automatic line_feed();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) scroll_screen();
      else cur_row = cur_row + 1;
   endtask

   task automatic print_char(logic [7:0] ch);
      put_cell(ch, colour, cur_col, cur_row);
      if (cur_col + 1 >= COLS) line_feed();
      else cur_col = cur_col + 1;
   endtask

   function automatic logic [3:0] hex_nibble(logic [7:0] b);
      int v;
      if (b <= 8'h39) v = int'(b) - 48;
      else if (b <= 8'h46) v = int'(b) - 55;
      else v = int'(b) - 87;
      return v[3:0];
   endfunction

   task automatic terminal_byte(logic [7:0] b);
      case (esc)
         ESC_OPEN: begin
            if (b == tmtw_pkg::CH_R) begin
               colour = tmtw_pkg::COLOR_BRIGHT;
               esc = ESC_IDLE;
            end else if (b == tmtw_pkg::CH_C) begin
               esc = ESC_FG;
            end else begin
               esc = ESC_IDLE;   // any other byte is swallowed
            end
         end
         ESC_FG: begin
            fg_nib = hex_nibble(b);
            esc = ESC_BG;
         end
         ESC_BG: begin
            colour = {hex_nibble(b), fg_nib};
            esc = ESC_IDLE;
         end
         default: begin
            if (b == tmtw_pkg::CH_ESC) esc = ESC_OPEN;
            else if (b == tmtw_pkg::CH_LF || b == tmtw_pkg::CH_CR) line_feed();
            else if (b == tmtw_pkg::CH_TAB) begin
               // at least one space, stop on a tab stop or a wrap to column 0
               do print_char(tmtw_pkg::CH_SPACE); while (cur_col % 8 != 0);
            end else if (b == tmtw_pkg::CH_BS) begin
               if (cur_col > 0) begin   // no-op at column 0
                  cur_col = cur_col - 1;
                  put_cell(8'h00, 8'h00, cur_col, cur_row);
               end
            end else print_char(b);
         end
      endcase
   endtask

   task automatic predict_beat(logic [1:0] mode, logic [7:0] ch, logic eow,
                               logic [10:0] cell_idx, logic [6:0] scol,
                               logic [4:0] srow);
      tmtw_pkg::rsp_type r;
      r.entry = 16'h0000;
      case (mode)
         tmtw_pkg::MODE_WRITE: begin
            terminal_byte(ch);
            if (eow) esc = ESC_IDLE;   // unfinished escape abandoned
         end
         tmtw_pkg::MODE_READ: if (cell_idx < CELLS) r.entry = screen[cell_idx];
         tmtw_pkg::MODE_SETCUR: begin
            cur_col = (scol < COLS) ? scol : 7'(COLS - 1);
            cur_row = (srow < ROWS) ? srow : 5'(ROWS - 1);
         end
         default: ;   // spare mode changes nothing
      endcase
      r.col   = cur_col;
      r.row   = cur_row;
      r.color = colour;
      expected_rsp.push_back(r);
   endtask

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   task automatic send_beat(logic [1:0] mode, logic [7:0] ch, logic eow,
                            logic [10:0] cell_idx, logic [6:0] scol, logic [4:0] srow);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tlast  <= eow;
      req_tdata  <= {1'b0, srow, scol, cell_idx, ch};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_beat(mode, ch, eow, cell_idx, scol, srow);
      if (idling && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 14)) @(negedge clock);
      end
   endtask

   task automatic send_byte(logic [7:0] ch, logic eow = 1'b0);
      send_beat(tmtw_pkg::MODE_WRITE, ch, eow, 11'($urandom_range(0, 2047)),
                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
   endtask

   task automatic send_read(logic [10:0] cell_idx);
      send_beat(tmtw_pkg::MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                cell_idx, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
   endtask

   task automatic send_cursor(logic [6:0] scol, logic [4:0] srow);
      send_beat(tmtw_pkg::MODE_SETCUR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                11'($urandom_range(0, 2047)), scol, srow);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic addr, logic val);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (addr == tmtw_pkg::CSR_REVERSE_ROWS) rev_rows = val;
      else keep_attr_off = val;
   endtask

   function automatic logic [7:0] hex_digit();
      case ($urandom_range(0, 4))
         0: return 8'($urandom_range(8'h30, 8'h39));
         1: return 8'($urandom_range(8'h41, 8'h46));
         2: return 8'($urandom_range(8'h61, 8'h66));
         default: return 8'($urandom_range(0, 255));   // out-of-range digits too
      endcase
   endfunction

   // One random beat or short sequence; mostly well-formed text and escapes.
   task automatic random_step();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) send_byte(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 15) == 0);
      else if (k < 55) send_byte($urandom_range(0, 1) ? tmtw_pkg::CH_LF : tmtw_pkg::CH_CR);
      else if (k < 59) send_byte(tmtw_pkg::CH_TAB);
      else if (k < 64) send_byte(tmtw_pkg::CH_BS);
      else if (k < 70) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (k < 78) begin
         send_byte(tmtw_pkg::CH_ESC);
         case ($urandom_range(0, 3))
            0: send_byte(tmtw_pkg::CH_R);
            1: send_byte(8'($urandom_range(0, 255)));
            default: begin
               send_byte(tmtw_pkg::CH_C, $urandom_range(0, 7) == 0);
               send_byte(hex_digit(), $urandom_range(0, 7) == 0);
               send_byte(hex_digit());
            end
         endcase
      end else if (k < 89) begin
         send_read($urandom_range(0, 3) == 0 ? 11'($urandom_range(0, 2047))
                                             : 11'($urandom_range(0, CELLS - 1)));
      end else if (k < 97) begin
         send_cursor(7'($urandom_range(0, 127)), 5'($urandom_range(0, 23)));
      end else begin
         send_beat(MODE_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   11'($urandom_range(0, 2047)), 7'($urandom_range(0, 127)),
                   5'($urandom_range(0, 31)));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: idle bursts and the one long hold-off
   // ---------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            hold_req = 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Checker: each response beat against the oldest prediction
   always @(posedge clock) begin
      tmtw_pkg::rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            fails++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_tdata[15:0] !== e.entry) begin
               $error("read_entry exp %h got %h", e.entry, rsp_tdata[15:0]);
               fails++;
            end
            if (rsp_tdata[22:16] !== e.col) begin
               $error("cursor_column exp %0d got %0d", e.col, rsp_tdata[22:16]);
               fails++;
            end
            if (rsp_tdata[27:23] !== e.row) begin
               $error("cursor_row exp %0d got %0d", e.row, rsp_tdata[27:23]);
               fails++;
            end
            if (rsp_tdata[35:28] !== e.color) begin
               $error("text_color exp %h got %h", e.color, rsp_tdata[35:28]);
               fails++;
            end
         end
      end
   end

   // Watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   task automatic test_directed();
      send_byte(8'h41);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_read(11'd0);
      send_byte(tmtw_pkg::CH_LF);
      send_byte(tmtw_pkg::CH_BS);        // column zero: nothing happens
      send_byte(8'h42);
      send_byte(tmtw_pkg::CH_CR);
      send_byte(tmtw_pkg::CH_TAB);
      send_byte(tmtw_pkg::CH_BS);
      send_byte(tmtw_pkg::CH_ESC); send_byte(tmtw_pkg::CH_R);
      send_byte(tmtw_pkg::CH_ESC); send_byte(tmtw_pkg::CH_C);
      send_byte(8'h7A); send_byte(8'h47);                          // odd digits
      send_byte(tmtw_pkg::CH_ESC); send_byte(8'h78);               // swallowed
      send_byte(tmtw_pkg::CH_ESC, 1'b1); // abandoned by end of write
      send_byte(tmtw_pkg::CH_ESC); send_read(11'd1999);
      send_byte(tmtw_pkg::CH_R);         // read inside escape
      send_read(11'd2000);
      send_read(11'd2047);
      send_cursor(7'd127, 5'd31);        // saturates
      send_byte(8'h58);                  // wrap at the bottom: scroll
      send_cursor(7'd76, 5'd24);
      send_byte(tmtw_pkg::CH_TAB);       // tab wraps and scrolls
      send_beat(MODE_SPARE, 8'hFF, 1'b1, 11'h7FF, 7'h7F, 5'h1F);
      send_cursor(7'd0, 5'd0);
   endtask

   task automatic test_random(int n);
      repeat (n) random_step();
   endtask

   task automatic test_registers();
      write_csr(tmtw_pkg::CSR_REVERSE_ROWS, 1'b1);
      test_random(200);
      write_csr(tmtw_pkg::CSR_WRITE_COLOR, 1'b0);
      test_random(200);
      write_csr(tmtw_pkg::CSR_REVERSE_ROWS, 1'b0);
      test_random(200);
      write_csr(tmtw_pkg::CSR_WRITE_COLOR, 1'b1);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_req = 1'b1;      // receiver stalls while requests keep coming
      test_random(60);
      wait_drained();       // sender pauses until all responses are in
      test_random(40);
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = 1'b0;
      csr_wdata  = 1'b0;
      fails      = 0;
      idling     = 1'b0;
      hold_req   = 1'b0;
      quiet_cycles = 0;
      for (int i = 0; i < CELLS; i++) screen[i] = tmtw_pkg::CELL_BLANK;
      cur_col = '0; cur_row = '0; colour = tmtw_pkg::COLOR_RESET;
      esc = ESC_IDLE; fg_nib = '0; rev_rows = 1'b0; keep_attr_off = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idling = 1'b1;
      test_directed();
      test_registers();
      test_random(360);
      test_backpressure();
      idling = 1'b0;        // final stretch runs flat out
      test_random(300);

      wait_drained();
      repeat (50) @(posedge clock);
      if (fails == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
